FILE: sv/rtpf_pkg.sv
`default_nettype none
package rtpf_pkg;

  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int PIXEL_BITS       = 10;
  localparam int TICK_BITS        = 32;
  localparam int CMD_BITS         = 2;
  localparam int CFG_IDX_BITS     = 3;

  localparam logic [15:0] RST_OUTSIDE_THR = 16'd3995;
  localparam logic [15:0] RST_X_CAL_MIN   = 16'd500;
  localparam logic [15:0] RST_X_CAL_MAX   = 16'd3460;
  localparam logic [15:0] RST_Y_CAL_MIN   = 16'd530;
  localparam logic [15:0] RST_Y_CAL_MAX   = 16'd3660;
  localparam logic [PIXEL_BITS-1:0] RST_SCREEN_W = 10'd240;
  localparam logic [PIXEL_BITS-1:0] RST_SCREEN_H = 10'd320;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INITIALIZED = 3'd0,
    REG_OUTSIDE_THR = 3'd1,
    REG_X_CAL_MIN   = 3'd2,
    REG_X_CAL_MAX   = 3'd3,
    REG_Y_CAL_MIN   = 3'd4,
    REG_Y_CAL_MAX   = 3'd5,
    REG_SCREEN_W    = 3'd6,
    REG_SCREEN_H    = 3'd7
  } reg_idx_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_PEN_DOWN = 2'd1,
    CMD_PEN_UP   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STS_SUCCESS  = 3'd0,
    STS_NO_TOUCH = 3'd1,
    STS_OUTSIDE  = 3'd2,
    STS_NOT_INIT = 3'd3,
    STS_ACK      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TS_IDLE = 2'd0,
    TS_DOWN = 2'd1,
    TS_MOVE = 2'd2
  } tstate_t;

  localparam logic [1:0] PT_NONE = 2'd0;
  localparam logic [1:0] PT_UP   = 2'd3;

  typedef struct packed {
    status_t    status;
    logic [1:0] point_state;
    tstate_t    cur_state;
    logic       do_map;
  } rtpf_job_t;

endpackage
`default_nettype wire

FILE: sv/rtpf_div.sv
`default_nettype none
module rtpf_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo
);

  localparam int NUM_P = NUM_W + (NUM_W % 2);
  localparam int STEPS = NUM_P / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_P-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // Two restoring steps per cycle; the remainder stays below the divisor whenever the divisor is nonzero.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    qbit    = 1'b0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_nxt, quo_nxt[NUM_P-1]};
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        qbit  = 1'b1;
      end else begin
        qbit  = 1'b0;
      end
      rem_nxt = trial[DEN_W-1:0];
      quo_nxt = {quo_nxt[NUM_P-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(STEPS);
    end else if (busy_r) begin
      busy_r <= (cnt_r != CNT_W'(1));
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= NUM_P'(num);
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r[NUM_W-1:0];

endmodule
`default_nettype wire

FILE: sv/rtpf_queue.sv
`default_nettype none
module rtpf_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              push_ready,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              pop_valid
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rtpf_front.sv
`default_nettype none
module rtpf_front #(
  parameter int SAMPLE_BITS  = rtpf_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_DEPTH = rtpf_pkg::WINDOW_DEPTH_DEF,
  parameter int SUM_W        = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rtpf_pkg::CMD_BITS-1:0]    in_cmd,
  input  wire logic [SAMPLE_BITS-1:0]           in_x_raw,
  input  wire logic [SAMPLE_BITS-1:0]           in_y_raw,
  input  wire logic                             cfg_initialized,
  input  wire logic [SAMPLE_BITS-1:0]           cfg_outside_thr,
  input  wire logic                             q_ready,
  output logic                                  q_push,
  output rtpf_pkg::rtpf_job_t                   job,
  output logic [SUM_W-1:0]                      x_sum,
  output logic [SUM_W-1:0]                      y_sum
);

  import rtpf_pkg::*;

  tstate_t                ts_r, ts_nxt;
  logic [SAMPLE_BITS-1:0] xwin_r [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] ywin_r [WINDOW_DEPTH];
  logic [SUM_W-1:0]       xsum_r, xsum_nxt;
  logic [SUM_W-1:0]       ysum_r, ysum_nxt;
  logic                   push_x, push_y;
  logic                   accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign q_push   = accept;

  always_comb begin
    ts_nxt           = ts_r;
    push_x           = 1'b0;
    push_y           = 1'b0;
    job.status       = STS_ACK;
    job.point_state  = PT_NONE;
    job.do_map       = 1'b0;
    case (cmd_t'(in_cmd))
      CMD_PEN_DOWN: begin
        if (ts_r == TS_IDLE) begin
          ts_nxt = TS_DOWN;
        end
      end
      CMD_PEN_UP: begin
        ts_nxt          = TS_IDLE;
        job.point_state = PT_UP;
      end
      CMD_SAMPLE: begin
        if (!cfg_initialized) begin
          job.status = STS_NOT_INIT;
        end else if (ts_r == TS_IDLE) begin
          job.status = STS_NO_TOUCH;
        end else begin
          push_x = 1'b1;
          if (in_x_raw > cfg_outside_thr) begin
            job.status = STS_OUTSIDE;
          end else begin
            push_y          = 1'b1;
            job.do_map      = 1'b1;
            job.point_state = ts_r;
            ts_nxt          = TS_MOVE;
            job.status      = STS_SUCCESS;
          end
        end
      end
      default: begin
      end
    endcase
    job.cur_state = ts_nxt;
  end

  // Running sums: drop the oldest entry and add the new reading.
  assign xsum_nxt = push_x ? (xsum_r - SUM_W'(xwin_r[0]) + SUM_W'(in_x_raw)) : xsum_r;
  assign ysum_nxt = push_y ? (ysum_r - SUM_W'(ywin_r[0]) + SUM_W'(in_y_raw)) : ysum_r;
  assign x_sum    = xsum_nxt;
  assign y_sum    = ysum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r   <= TS_IDLE;
      xsum_r <= '0;
      ysum_r <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        xwin_r[i] <= '0;
        ywin_r[i] <= '0;
      end
    end else if (accept) begin
      ts_r   <= ts_nxt;
      xsum_r <= xsum_nxt;
      ysum_r <= ysum_nxt;
      if (push_x) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          xwin_r[i] <= xwin_r[i+1];
        end
        xwin_r[WINDOW_DEPTH-1] <= in_x_raw;
      end
      if (push_y) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          ywin_r[i] <= ywin_r[i+1];
        end
        ywin_r[WINDOW_DEPTH-1] <= in_y_raw;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/rtpf_back.sv
`default_nettype none
module rtpf_back #(
  parameter int SAMPLE_BITS  = rtpf_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_DEPTH = rtpf_pkg::WINDOW_DEPTH_DEF,
  parameter int SUM_W        = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                job_valid,
  output logic                                     job_pop,
  input  wire rtpf_pkg::rtpf_job_t                 job,
  input  wire logic [rtpf_pkg::TICK_BITS-1:0]      job_tick,
  input  wire logic [SUM_W-1:0]                    job_x_sum,
  input  wire logic [SUM_W-1:0]                    job_y_sum,
  input  wire logic [SAMPLE_BITS-1:0]              x_lo,
  input  wire logic [SAMPLE_BITS-1:0]              x_hi,
  input  wire logic [SAMPLE_BITS-1:0]              y_lo,
  input  wire logic [SAMPLE_BITS-1:0]              y_hi,
  input  wire logic [rtpf_pkg::PIXEL_BITS-1:0]     scr_w,
  input  wire logic [rtpf_pkg::PIXEL_BITS-1:0]     scr_h,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               out_status,
  output logic [rtpf_pkg::PIXEL_BITS-1:0]          out_x_pixel,
  output logic [rtpf_pkg::PIXEL_BITS-1:0]          out_y_pixel,
  output logic [1:0]                               out_point_state,
  output logic [rtpf_pkg::TICK_BITS-1:0]           out_point_tick,
  output logic [1:0]                               out_current_state
);

  import rtpf_pkg::*;

  localparam int NUM_W  = SAMPLE_BITS + PIXEL_BITS;
  localparam int AVG_SH = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int REC_W  = SUM_W + 1;
  localparam int AVGP_W = SUM_W + REC_W;
  localparam logic [63:0] AVG_REC_FULL =
    ((64'd1 << AVG_SH) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH);
  localparam logic [REC_W-1:0] AVG_REC = AVG_REC_FULL[REC_W-1:0];

  typedef enum logic [6:0] {
    B_IDLE   = 7'b0000001,
    B_AVG    = 7'b0000010,
    B_CLAMP  = 7'b0000100,
    B_MUL    = 7'b0001000,
    B_MSTART = 7'b0010000,
    B_MAP    = 7'b0100000,
    B_DONE   = 7'b1000000
  } bstate_t;

  bstate_t                state_r, state_nxt;
  rtpf_job_t              job_r;
  logic [TICK_BITS-1:0]   tick_r;
  logic [SUM_W-1:0]       xs_r, ys_r;
  logic [SAMPLE_BITS-1:0] xavg_r, yavg_r;
  logic [SAMPLE_BITS-1:0] xd_r, yd_r;
  logic [NUM_W-1:0]       xprod_r, yprod_r;
  logic [PIXEL_BITS-1:0]  xp_r, yp_r;
  logic                   out_valid_r;
  logic [2:0]             out_status_r;
  logic [PIXEL_BITS-1:0]  out_xp_r, out_yp_r;
  logic [1:0]             out_ps_r, out_cs_r;
  logic [TICK_BITS-1:0]   out_tick_r;

  logic                   div_start;
  logic [AVGP_W-1:0]      xavg_prod, yavg_prod;
  logic [NUM_W-1:0]       xdiv_num, ydiv_num, xquo, yquo;
  logic [SAMPLE_BITS-1:0] xdiv_den, ydiv_den;
  logic                   xbusy, ybusy;
  logic                   out_load;

  function automatic logic [SAMPLE_BITS-1:0] clamp_diff(
    input logic [SAMPLE_BITS-1:0] avg,
    input logic [SAMPLE_BITS-1:0] lo,
    input logic [SAMPLE_BITS-1:0] hi
  );
    logic [SAMPLE_BITS-1:0] c;
    c = (avg < lo) ? lo : ((avg > hi) ? hi : avg);
    return hi - c;
  endfunction

  assign job_pop   = (state_r == B_IDLE) && job_valid;
  assign div_start = (state_r == B_MSTART);
  assign out_load  = (state_r == B_DONE) && (!out_valid_r || out_ready);

  // The window average is the sum times the rounded-up reciprocal of the depth,
  // which is exact for every sum the window can hold.
  assign xavg_prod = AVGP_W'(xs_r) * AVGP_W'(AVG_REC);
  assign yavg_prod = AVGP_W'(ys_r) * AVGP_W'(AVG_REC);

  assign xdiv_num = xprod_r;
  assign ydiv_num = yprod_r;
  assign xdiv_den = x_hi - x_lo;
  assign ydiv_den = y_hi - y_lo;

  rtpf_div #(.NUM_W(NUM_W), .DEN_W(SAMPLE_BITS)) u_xdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (xdiv_num),
    .den   (xdiv_den),
    .busy  (xbusy),
    .quo   (xquo)
  );

  rtpf_div #(.NUM_W(NUM_W), .DEN_W(SAMPLE_BITS)) u_ydiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ydiv_num),
    .den   (ydiv_den),
    .busy  (ybusy),
    .quo   (yquo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          state_nxt = job.do_map ? B_AVG : B_DONE;
        end
      end
      B_AVG: begin
        state_nxt = B_CLAMP;
      end
      B_CLAMP: begin
        state_nxt = B_MUL;
      end
      B_MUL: begin
        state_nxt = B_MSTART;
      end
      B_MSTART: begin
        state_nxt = B_MAP;
      end
      B_MAP: begin
        if (!xbusy && !ybusy) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r  <= job;
      tick_r <= job_tick;
      xs_r   <= job_x_sum;
      ys_r   <= job_y_sum;
      xp_r   <= '0;
      yp_r   <= '0;
    end
    if (state_r == B_AVG) begin
      xavg_r <= xavg_prod[AVG_SH +: SAMPLE_BITS];
      yavg_r <= yavg_prod[AVG_SH +: SAMPLE_BITS];
    end
    if (state_r == B_CLAMP) begin
      xd_r <= clamp_diff(xavg_r, x_lo, x_hi);
      yd_r <= clamp_diff(yavg_r, y_lo, y_hi);
    end
    if (state_r == B_MUL) begin
      xprod_r <= NUM_W'(xd_r) * NUM_W'(scr_w);
      yprod_r <= NUM_W'(yd_r) * NUM_W'(scr_h);
    end
    if ((state_r == B_MAP) && !xbusy && !ybusy) begin
      xp_r <= (x_hi > x_lo) ? xquo[PIXEL_BITS-1:0] : '0;
      yp_r <= (y_hi > y_lo) ? yquo[PIXEL_BITS-1:0] : '0;
    end
    if (out_load) begin
      out_status_r <= job_r.status;
      out_xp_r     <= xp_r;
      out_yp_r     <= yp_r;
      out_ps_r     <= job_r.point_state;
      out_cs_r     <= job_r.cur_state;
      out_tick_r   <= tick_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_x_pixel       = out_xp_r;
  assign out_y_pixel       = out_yp_r;
  assign out_point_state   = out_ps_r;
  assign out_point_tick    = out_tick_r;
  assign out_current_state = out_cs_r;

endmodule
`default_nettype wire

FILE: sv/resistive_touch_point_filter.sv
`default_nettype none
// Touch point filter for a resistive panel. Pen-down, pen-up and sample events enter on
// the input channel and each one gives exactly one result. A sample that needs mapping
// holds the back end while a reciprocal multiply forms each window average, the clamped
// average is scaled by the screen size, and a pair of radix-4 restoring dividers divide
// it by the calibration span. Events and samples that report a status without
// coordinates skip these steps and go straight to the result. The front end updates the
// touch state and the moving-average windows as soon as an item is accepted and hands it
// to a two-entry queue, so up to two further input transfers go ahead while the back end
// is busy or a result waits.
module resistive_touch_point_filter #(
  parameter int SAMPLE_BITS  = rtpf_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_DEPTH = rtpf_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rtpf_pkg::CMD_BITS-1:0]       in_cmd,
  input  wire logic [SAMPLE_BITS-1:0]              in_x_raw,
  input  wire logic [SAMPLE_BITS-1:0]              in_y_raw,
  input  wire logic [rtpf_pkg::TICK_BITS-1:0]      in_tick,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               out_status,
  output logic [rtpf_pkg::PIXEL_BITS-1:0]          out_x_pixel,
  output logic [rtpf_pkg::PIXEL_BITS-1:0]          out_y_pixel,
  output logic [1:0]                               out_point_state,
  output logic [rtpf_pkg::TICK_BITS-1:0]           out_point_tick,
  output logic [1:0]                               out_current_state,
  input  wire logic                                cfg_we,
  input  wire logic [rtpf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [((SAMPLE_BITS > rtpf_pkg::PIXEL_BITS) ?
                      SAMPLE_BITS : rtpf_pkg::PIXEL_BITS)-1:0] cfg_wdata
);

  import rtpf_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int JOB_W = $bits(rtpf_job_t) + TICK_BITS + 2 * SUM_W;

  logic                   init_r;
  logic [SAMPLE_BITS-1:0] thr_r, xmin_r, xmax_r, ymin_r, ymax_r;
  logic [PIXEL_BITS-1:0]  scr_w_r, scr_h_r;

  rtpf_job_t              f_job, b_job;
  logic [SUM_W-1:0]       f_xsum, f_ysum, b_xsum, b_ysum;
  logic [TICK_BITS-1:0]   b_tick;
  logic                   q_push, q_ready, q_pop, q_valid;
  logic [JOB_W-1:0]       q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= 1'b0;
      thr_r   <= SAMPLE_BITS'(RST_OUTSIDE_THR);
      xmin_r  <= SAMPLE_BITS'(RST_X_CAL_MIN);
      xmax_r  <= SAMPLE_BITS'(RST_X_CAL_MAX);
      ymin_r  <= SAMPLE_BITS'(RST_Y_CAL_MIN);
      ymax_r  <= SAMPLE_BITS'(RST_Y_CAL_MAX);
      scr_w_r <= RST_SCREEN_W;
      scr_h_r <= RST_SCREEN_H;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INITIALIZED: init_r  <= cfg_wdata[0];
        REG_OUTSIDE_THR: thr_r   <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_X_CAL_MIN:   xmin_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_X_CAL_MAX:   xmax_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_Y_CAL_MIN:   ymin_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_Y_CAL_MAX:   ymax_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_SCREEN_W:    scr_w_r <= cfg_wdata[PIXEL_BITS-1:0];
        REG_SCREEN_H:    scr_h_r <= cfg_wdata[PIXEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rtpf_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_x_raw        (in_x_raw),
    .in_y_raw        (in_y_raw),
    .cfg_initialized (init_r),
    .cfg_outside_thr (thr_r),
    .q_ready         (q_ready),
    .q_push          (q_push),
    .job             (f_job),
    .x_sum           (f_xsum),
    .y_sum           (f_ysum)
  );

  assign q_wdata = {f_job, in_tick, f_xsum, f_ysum};

  rtpf_queue #(.W(JOB_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_rdata),
    .pop_valid  (q_valid)
  );

  assign {b_job, b_tick, b_xsum, b_ysum} = q_rdata;

  rtpf_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (q_valid),
    .job_pop           (q_pop),
    .job               (b_job),
    .job_tick          (b_tick),
    .job_x_sum         (b_xsum),
    .job_y_sum         (b_ysum),
    .x_lo              (xmin_r),
    .x_hi              (xmax_r),
    .y_lo              (ymin_r),
    .y_hi              (ymax_r),
    .scr_w             (scr_w_r),
    .scr_h             (scr_h_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_x_pixel       (out_x_pixel),
    .out_y_pixel       (out_y_pixel),
    .out_point_state   (out_point_state),
    .out_point_tick    (out_point_tick),
    .out_current_state (out_current_state)
  );

endmodule
`default_nettype wire
